// File: design/assert_macros.svh
// Assertion macros shared by the rate meter RTL.
// Included by files that check their own sequencing; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/trm_pkg.sv
// Types and constants for the totalizer rate meter.
// Used by trm_divider and totalizer_rate_meter_unit; no dependencies.
package trm_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int SCALE_WIDTH   = 13;
   localparam int PRODUCT_WIDTH = VALUE_WIDTH + SCALE_WIDTH;

   localparam logic [SCALE_WIDTH-1:0] RATE_SCALE = 13'd6000;
   localparam logic [VALUE_WIDTH-1:0] RATE_MAX   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] total_volume_ul;
      logic        total_is_valid;
      logic [31:0] report_time_ms;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] rate_centi_ml_min;
      logic        rate_saturated;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_DELIVER
   } trm_state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: design/trm_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on trm_pkg for control and status structs and default widths.
module trm_divider #(
   parameter int DIVIDEND_WIDTH = trm_pkg::PRODUCT_WIDTH,
   parameter int DIVISOR_WIDTH  = trm_pkg::VALUE_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  trm_pkg::div_ctrl_type        div_ctrl,
   input  logic [DIVIDEND_WIDTH-1:0]    dividend,
   input  logic [DIVISOR_WIDTH-1:0]     divisor,
   output trm_pkg::div_status_type      div_status,
   output logic [DIVIDEND_WIDTH-1:0]    quotient
);

   localparam int COUNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);
   localparam logic [COUNT_WIDTH-1:0] STEP_COUNT = COUNT_WIDTH'(DIVIDEND_WIDTH);
   localparam logic [COUNT_WIDTH-1:0] LAST_STEP  = COUNT_WIDTH'(1);

   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      done_ff, done_in;
   logic [DIVIDEND_WIDTH-1:0] quotient_ff, quotient_in;
   logic [DIVISOR_WIDTH-1:0]  remainder_ff, remainder_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]    partial;
   logic [DIVISOR_WIDTH:0]    difference;
   logic                      fits;

   assign partial    = {remainder_ff, quotient_ff[DIVIDEND_WIDTH-1]};
   assign difference = partial - {1'b0, divisor_ff};
   assign fits       = ~difference[DIVISOR_WIDTH];

   always_comb begin
      count_in     = count_ff;
      done_in      = 1'b0;
      quotient_in  = quotient_ff;
      remainder_in = remainder_ff;
      divisor_in   = divisor_ff;
      if (div_ctrl.start) begin
         count_in     = STEP_COUNT;
         quotient_in  = dividend;
         remainder_in = '0;
         divisor_in   = divisor;
      end else if (count_ff != '0) begin
         count_in     = count_ff - LAST_STEP;
         done_in      = (count_ff == LAST_STEP);
         quotient_in  = {quotient_ff[DIVIDEND_WIDTH-2:0], fits};
         remainder_in = fits ? difference[DIVISOR_WIDTH-1:0] : partial[DIVISOR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff  <= quotient_in;
      remainder_ff <= remainder_in;
      divisor_ff   <= divisor_in;
   end

   assign div_status.busy = (count_ff != '0);
   assign div_status.done = done_ff;
   assign quotient        = quotient_ff;

endmodule

// File: design/totalizer_rate_meter_unit.sv
// An accepted report passes through the scale, launch, divide and deliver states;
// an invalid or zero-elapsed report goes from scale straight to deliver. The
// divide state waits on the 45-step serial divider. A new report is taken while the
// previous result still waits in the output register, but only after it is loaded.
// Reset (synchronous, active high): previous time zero, no volume reference, outputs empty.
// Depends on trm_pkg, trm_divider and assert_macros.svh.
`include "assert_macros.svh"

module totalizer_rate_meter_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  trm_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output trm_pkg::rsp_payload_type rsp_payload
);

   localparam int VW = trm_pkg::VALUE_WIDTH;
   localparam int PW = trm_pkg::PRODUCT_WIDTH;

   trm_pkg::trm_state_type   state_ff, state_in;
   trm_pkg::div_ctrl_type    div_ctrl;
   trm_pkg::div_status_type  div_status;
   trm_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [VW-1:0] previous_time_ff, previous_time_in;
   logic [VW-1:0] previous_total_ff, previous_total_in;
   logic          reference_ff, reference_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] delta_ff, delta_in;
   logic [VW-1:0] elapsed_ff, elapsed_in;
   logic          zero_ff, zero_in;
   logic [PW-1:0] product_ff, product_in;
   logic [PW-1:0] quotient;
   logic          req_transfer;
   logic          slot_free;
   logic          load_rsp;
   logic          overflow;

   assign req_transfer = req_valid && req_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign overflow     = (quotient[PW-1:VW] != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trm_pkg::ST_IDLE: begin
            if (req_valid) state_in = trm_pkg::ST_SCALE;
         end
         trm_pkg::ST_SCALE: begin
            state_in = zero_ff ? trm_pkg::ST_DELIVER : trm_pkg::ST_LAUNCH;
         end
         trm_pkg::ST_LAUNCH: begin
            state_in = trm_pkg::ST_DIVIDE;
         end
         trm_pkg::ST_DIVIDE: begin
            if (div_status.done) state_in = trm_pkg::ST_DELIVER;
         end
         trm_pkg::ST_DELIVER: begin
            if (slot_free) state_in = trm_pkg::ST_IDLE;
         end
         default: begin
            state_in = trm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      div_ctrl.start = 1'b0;
      load_rsp       = 1'b0;
      case (state_ff)
         trm_pkg::ST_IDLE:    req_ready      = 1'b1;
         trm_pkg::ST_LAUNCH:  div_ctrl.start = 1'b1;
         trm_pkg::ST_DELIVER: load_rsp       = slot_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      previous_time_in  = previous_time_ff;
      previous_total_in = previous_total_ff;
      reference_in      = reference_ff;
      delta_in          = delta_ff;
      elapsed_in        = elapsed_ff;
      zero_in           = zero_ff;
      if (req_transfer) begin
         previous_time_in = req_payload.report_time_ms;
         elapsed_in       = req_payload.report_time_ms - previous_time_ff;
         zero_in          = !req_payload.total_is_valid ||
                            (req_payload.report_time_ms == previous_time_ff);
         if (!reference_ff) begin
            delta_in = '0;
         end else if (req_payload.total_volume_ul >= previous_total_ff) begin
            delta_in = req_payload.total_volume_ul - previous_total_ff;
         end else begin
            delta_in = req_payload.total_volume_ul;
         end
         if (req_payload.total_is_valid) begin
            previous_total_in = req_payload.total_volume_ul;
            reference_in      = 1'b1;
         end
      end
   end

   assign product_in = PW'(delta_ff) * PW'(trm_pkg::RATE_SCALE);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (zero_ff) begin
            rsp_payload_in.rate_centi_ml_min = '0;
            rsp_payload_in.rate_saturated    = 1'b0;
         end else if (overflow) begin
            rsp_payload_in.rate_centi_ml_min = trm_pkg::RATE_MAX;
            rsp_payload_in.rate_saturated    = 1'b1;
         end else begin
            rsp_payload_in.rate_centi_ml_min = quotient[VW-1:0];
            rsp_payload_in.rate_saturated    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= trm_pkg::ST_IDLE;
         previous_time_ff  <= '0;
         previous_total_ff <= '0;
         reference_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         previous_time_ff  <= previous_time_in;
         previous_total_ff <= previous_total_in;
         reference_ff      <= reference_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff       <= delta_in;
      elapsed_ff     <= elapsed_in;
      zero_ff        <= zero_in;
      product_ff     <= product_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   trm_divider #(
      .DIVIDEND_WIDTH (PW),
      .DIVISOR_WIDTH  (VW)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .div_ctrl   (div_ctrl),
      .dividend   (product_ff),
      .divisor    (elapsed_ff),
      .div_status (div_status),
      .quotient   (quotient)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_IMPLIES(a_done_in_divide, clock, reset, div_status.done, state_ff == trm_pkg::ST_DIVIDE, "divider finished outside divide state")
   `ASSERT_IMPLIES(a_launch_idle_divider, clock, reset, div_ctrl.start, !div_status.busy, "divider launched while busy")
   `ASSERT_NEXT(a_transfer_scales, clock, reset, req_transfer, state_ff == trm_pkg::ST_SCALE, "accepted report did not enter scale state")
   `ASSERT_NEXT(a_deliver_loads, clock, reset, load_rsp, rsp_valid_ff, "delivered result not held in output register")
   `ASSERT_IMPLIES(a_saturated_max, clock, reset, rsp_valid_ff && rsp_payload_ff.rate_saturated, rsp_payload_ff.rate_centi_ml_min == trm_pkg::RATE_MAX, "saturated rate not clamped")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for totalizer_rate_meter_unit: directed table, then random reports.
// Holds its own rate predictor and a queue of expected results; depends on trm_pkg and totalizer_rate_meter_unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT       = 5000;
   localparam int DRAIN_CYCLES         = 60;
   localparam int REPORTS_PER_PHASE    = 610;
   localparam int MISMATCH_PRINT_LIMIT = 10;

   typedef struct {
      trm_pkg::req_payload_type report;
      bit                       typed;
      trm_pkg::rsp_payload_type result;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   trm_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   trm_pkg::rsp_payload_type rsp_payload;

   trm_pkg::rsp_payload_type expected_rates[$];
   directed_row_type         directed_rows[$];

   logic [31:0] meter_prev_time;
   logic [31:0] meter_prev_total;
   logic        meter_has_reference;

   int          send_idle_pct;
   int          rsp_idle_pct;
   bit          long_hold_request;
   int          mismatch_count;
   trm_pkg::rsp_payload_type oldest_rate;

   totalizer_rate_meter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic trm_pkg::rsp_payload_type predict_rate(
      input trm_pkg::req_payload_type report);
      trm_pkg::rsp_payload_type rate;
      logic [31:0]     elapsed;
      logic [31:0]     delta;
      logic [63:0]     quotient;
      rate = '0;
      elapsed = report.report_time_ms - meter_prev_time;
      meter_prev_time = report.report_time_ms;
      if (report.total_is_valid) begin
         if (!meter_has_reference)
            delta = '0;
         else if (report.total_volume_ul >= meter_prev_total)
            delta = report.total_volume_ul - meter_prev_total;
         else
            delta = report.total_volume_ul;
         meter_prev_total = report.total_volume_ul;
         meter_has_reference = 1'b1;
         if (elapsed != 32'd0) begin
            quotient = ({32'd0, delta} * {51'd0, trm_pkg::RATE_SCALE}) / {32'd0, elapsed};
            if (quotient > {32'd0, trm_pkg::RATE_MAX}) begin
               rate.rate_centi_ml_min = trm_pkg::RATE_MAX;
               rate.rate_saturated    = 1'b1;
            end else begin
               rate.rate_centi_ml_min = quotient[31:0];
            end
         end
      end
      return rate;
   endfunction

   task automatic add_row(input logic [31:0] total, input logic valid, input logic [31:0] stamp,
                          input bit typed, input logic [31:0] rate, input logic saturated);
      directed_row_type row;
      row.report.total_volume_ul   = total;
      row.report.total_is_valid    = valid;
      row.report.report_time_ms    = stamp;
      row.typed                    = typed;
      row.result.rate_centi_ml_min = rate;
      row.result.rate_saturated    = saturated;
      directed_rows.push_back(row);
   endtask

   task automatic send_report(input trm_pkg::req_payload_type report, input bit typed,
                              input trm_pkg::rsp_payload_type typed_rate);
      trm_pkg::rsp_payload_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= report;
      do @(posedge clock); while (!req_ready);
      predicted = predict_rate(report);
      expected_rates.push_back(typed ? typed_rate : predicted);
   endtask

   // receiver: random backpressure, with one long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_PRINT_LIMIT)
               $display("unexpected result: rate=%0d saturated=%0b",
                        rsp_payload.rate_centi_ml_min, rsp_payload.rate_saturated);
         end else begin
            oldest_rate = expected_rates.pop_front();
            if (rsp_payload.rate_centi_ml_min !== oldest_rate.rate_centi_ml_min ||
                rsp_payload.rate_saturated !== oldest_rate.rate_saturated) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_PRINT_LIMIT)
                  $display("rate mismatch: expected %0d/%0b, got %0d/%0b",
                           oldest_rate.rate_centi_ml_min, oldest_rate.rate_saturated,
                           rsp_payload.rate_centi_ml_min, rsp_payload.rate_saturated);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      trm_pkg::req_payload_type report;
      trm_pkg::rsp_payload_type no_rate;
      logic [31:0]     board_total;
      logic [31:0]     board_time;
      int              kind;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_payload         = '0;
      long_hold_request   = 1'b0;
      mismatch_count      = 0;
      meter_prev_time     = '0;
      meter_prev_total    = '0;
      meter_has_reference = 1'b0;
      no_rate             = '0;
      send_idle_pct       = 7;
      rsp_idle_pct        = 52;

      add_row(32'd100,        1'b0, 32'd0,          1, 32'd0,        1'b0);
      add_row(32'hFFFF_FFFF,  1'b1, 32'd10,         1, 32'd0,        1'b0);
      add_row(32'hFFFF_FFFF,  1'b1, 32'd10,         1, 32'd0,        1'b0);
      add_row(32'd0,          1'b1, 32'd11,         1, 32'd0,        1'b0);
      add_row(32'hFFFF_FFFF,  1'b1, 32'd12,         1, 32'hFFFF_FFFF, 1'b1);
      add_row(32'd0,          1'b1, 32'hFFFF_FFFF,  1, 32'd0,        1'b0);
      add_row(32'd1000,       1'b1, 32'd0,          0, 32'd0,        1'b0);
      add_row(32'd2000,       1'b1, 32'hFFFF_FFFF,  0, 32'd0,        1'b0);
      add_row(32'hFFFF_FFFF,  1'b0, 32'hFFFF_FFFF,  1, 32'd0,        1'b0);
      add_row(32'd1500,       1'b1, 32'd4,          0, 32'd0,        1'b0);
      add_row(32'd0,          1'b0, 32'd100,        1, 32'd0,        1'b0);
      add_row(32'd2500,       1'b1, 32'd200,        0, 32'd0,        1'b0);
      add_row(32'd718327,     1'b1, 32'd201,        0, 32'd0,        1'b0);
      add_row(32'd1434155,    1'b1, 32'd202,        1, 32'hFFFF_FFFF, 1'b1);
      add_row(32'd1434156,    1'b1, 32'd202,        1, 32'd0,        1'b0);
      add_row(32'd1434156,    1'b1, 32'h8000_0000,  0, 32'd0,        1'b0);
      add_row(32'hFFFF_FFFF,  1'b1, 32'h8000_0001,  0, 32'd0,        1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_report(directed_rows[i].report, directed_rows[i].typed, directed_rows[i].result);

      board_total = 32'd0;
      board_time  = 32'h8000_0001;
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 52;
            rsp_idle_pct  = 7;
         end else if (phase == 2) begin
            send_idle_pct     = 0;
            rsp_idle_pct      = 0;
            long_hold_request = 1'b1;
         end
         for (int n = 0; n < REPORTS_PER_PHASE; n++) begin
            kind = $urandom_range(99);
            report.total_is_valid = 1'b1;
            if (kind < 60) begin
               board_time  += $urandom_range(40, 1);
               board_total += $urandom_range(3000, 0);
               report.total_is_valid = ($urandom_range(99) >= 5);
            end else if (kind < 70) begin
               board_time += $urandom_range(40, 1);
               report.total_is_valid = 1'b0;
            end else if (kind < 78) begin
               board_time  += $urandom_range(40, 1);
               board_total  = $urandom_range(5000, 0);
            end else if (kind < 86) begin
               board_total += $urandom_range(3000, 0);
            end else if (kind < 92) begin
               board_time  += $urandom_range(2, 1);
               board_total += $urandom_range(1432000, 700000);
            end else begin
               board_time  = $urandom;
               board_total = $urandom;
               report.total_is_valid = $urandom_range(1, 0);
            end
            report.report_time_ms  = board_time;
            report.total_volume_ul = (kind >= 60 && kind < 70) ? $urandom : board_total;
            send_report(report, 0, no_rate);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      while (expected_rates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_rates.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
